// File: design/rfb_pkg.sv
// Shared types, constants and CRC function for the radio frame builder.
package rfb_pkg;

   // Frame geometry
   localparam int unsigned PACKET_BYTES = 128;
   localparam logic [7:0]  LEN_BYTE     = 8'(PACKET_BYTES);
   localparam int unsigned POS_W        = 8;
   localparam logic [5:0]  AMBLE_MAX    = 6'd32;

   // CRC-16 CCITT-FALSE
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_MSB  = 16'h8000;

   // Configuration register reset values
   localparam logic [5:0] PREAMBLE_RST  = 6'd16;
   localparam logic [5:0] POSTAMBLE_RST = 6'd10;
   localparam logic [7:0] SYNC_RST      = 8'h7E;
   localparam logic [7:0] FILL_RST      = 8'hAA;

   // Configuration port
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_PREAMBLE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POSTAMBLE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL      = 3'd3;

   // Queue between front and back
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   // One classified payload byte
   typedef struct packed {
      logic [7:0]  data;
      logic        first;
      logic        last;
      logic [15:0] crc;
   } rfb_entry_type;

   // Push request from front to queue
   typedef struct packed {
      logic          valid;
      rfb_entry_type entry;
   } rfb_push_type;

   // Configuration seen by the back end
   typedef struct packed {
      logic [5:0] preamble;
      logic [5:0] postamble;
      logic [7:0] sync;
      logic [7:0] fill;
   } rfb_cfg_type;

   // Back-end sequencer states
   typedef enum logic [6:0] {
      S_DATA = 7'b0000001,
      S_PRE  = 7'b0000010,
      S_SYNC = 7'b0000100,
      S_LEN  = 7'b0001000,
      S_CRCH = 7'b0010000,
      S_CRCL = 7'b0100000,
      S_POST = 7'b1000000
   } rfb_state_type;

   // Feed one byte into the CRC, MSB first
   function automatic logic [15:0] crc_feed(input logic [15:0] crc_i, input logic [7:0] b);
      logic [15:0] c;
      c = crc_i ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_MSB) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   // CRC after the length byte
   localparam logic [15:0] CRC_AFTER_LEN = crc_feed(CRC_INIT, LEN_BYTE);

endpackage

// File: design/rfb_front.sv
// Front end: accepts payload bytes, tracks frame position and running CRC.
module rfb_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_payload_byte,
   input  logic                fifo_full,
   output rfb_pkg::rfb_push_type push
);

   logic [rfb_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [15:0]               crc_ff, crc_in;
   logic                      take;
   logic                      first;
   logic                      last;
   logic [15:0]               crc_base;
   logic [15:0]               crc_new;

   assign req_ready = !fifo_full;
   assign take      = req_valid && req_ready;

   // Classify the byte and update the CRC
   always_comb begin
      first    = (pos_ff == '0);
      last     = (pos_ff >= rfb_pkg::POS_W'(rfb_pkg::PACKET_BYTES - 1));
      crc_base = first ? rfb_pkg::CRC_AFTER_LEN : crc_ff;
      crc_new  = rfb_pkg::crc_feed(crc_base, req_payload_byte);
      pos_in   = pos_ff;
      crc_in   = crc_ff;
      if (take) begin
         pos_in = last ? '0 : pos_ff + 1'b1;
         crc_in = last ? rfb_pkg::CRC_INIT : crc_new;
      end
   end

   assign push.valid       = take;
   assign push.entry.data  = req_payload_byte;
   assign push.entry.first = first;
   assign push.entry.last  = last;
   assign push.entry.crc   = crc_new;

   // Hold position and CRC
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         crc_ff <= rfb_pkg::CRC_INIT;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
      end
   end

endmodule

// File: design/rfb_fifo.sv
// Short queue of classified payload bytes between front and back end.
module rfb_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  rfb_pkg::rfb_push_type  push,
   output logic                   full,
   output logic                   head_valid,
   output rfb_pkg::rfb_entry_type head,
   input  logic                   pop
);

   rfb_pkg::rfb_entry_type            mem_ff [rfb_pkg::FIFO_DEPTH];
   logic [rfb_pkg::FIFO_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [rfb_pkg::FIFO_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [rfb_pkg::FIFO_CW-1:0]       count_ff, count_in;
   logic                              do_pop;

   assign full       = (count_ff == rfb_pkg::FIFO_CW'(rfb_pkg::FIFO_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

// File: design/rfb_back.sv
// Back end: sequences header, payload, CRC and postamble onto the line.
module rfb_back (
   input  logic                   clock,
   input  logic                   reset,
   input  rfb_pkg::rfb_cfg_type   cfg,
   input  logic                   head_valid,
   input  rfb_pkg::rfb_entry_type head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_line_byte,
   output logic                   rsp_frame_end
);

   rfb_pkg::rfb_state_type state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        hdr_done_ff, hdr_done_in;
   logic [15:0] crc_hold_ff, crc_hold_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_line_byte_ff, rsp_line_byte_in;
   logic        rsp_frame_end_ff, rsp_frame_end_in;

   logic        out_load;
   logic        emit;
   logic [7:0]  emit_byte;
   logic        emit_end;
   logic [5:0]  pre_eff;
   logic [5:0]  post_eff;
   logic [5:0]  cnt_next;

   // Clamp amble lengths
   assign pre_eff  = (cfg.preamble > rfb_pkg::AMBLE_MAX) ? rfb_pkg::AMBLE_MAX : cfg.preamble;
   assign post_eff = (cfg.postamble > rfb_pkg::AMBLE_MAX) ? rfb_pkg::AMBLE_MAX : cfg.postamble;
   assign cnt_next = cnt_ff + 6'd1;
   assign out_load = !rsp_valid_ff || rsp_ready;

   // Sequence the frame bytes
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      hdr_done_in = hdr_done_ff;
      crc_hold_in = crc_hold_ff;
      emit        = 1'b0;
      emit_byte   = cfg.fill;
      emit_end    = 1'b0;
      pop         = 1'b0;
      if (out_load) begin
         case (state_ff)
            rfb_pkg::S_DATA: begin
               if (head_valid) begin
                  emit = 1'b1;
                  if (head.first && !hdr_done_ff) begin
                     if (pre_eff == '0) begin
                        emit_byte = cfg.sync;
                        state_in  = rfb_pkg::S_LEN;
                     end else begin
                        emit_byte = cfg.fill;
                        cnt_in    = 6'd1;
                        state_in  = (pre_eff == 6'd1) ? rfb_pkg::S_SYNC : rfb_pkg::S_PRE;
                     end
                  end else begin
                     emit_byte   = head.data;
                     pop         = 1'b1;
                     hdr_done_in = 1'b0;
                     if (head.last) begin
                        crc_hold_in = head.crc;
                        state_in    = rfb_pkg::S_CRCH;
                     end
                  end
               end
            end
            rfb_pkg::S_PRE: begin
               emit      = 1'b1;
               emit_byte = cfg.fill;
               cnt_in    = cnt_next;
               if (cnt_next == pre_eff) begin
                  state_in = rfb_pkg::S_SYNC;
               end
            end
            rfb_pkg::S_SYNC: begin
               emit      = 1'b1;
               emit_byte = cfg.sync;
               state_in  = rfb_pkg::S_LEN;
            end
            rfb_pkg::S_LEN: begin
               emit        = 1'b1;
               emit_byte   = rfb_pkg::LEN_BYTE;
               hdr_done_in = 1'b1;
               state_in    = rfb_pkg::S_DATA;
            end
            rfb_pkg::S_CRCH: begin
               emit      = 1'b1;
               emit_byte = crc_hold_ff[15:8];
               state_in  = rfb_pkg::S_CRCL;
            end
            rfb_pkg::S_CRCL: begin
               emit      = 1'b1;
               emit_byte = crc_hold_ff[7:0];
               emit_end  = (post_eff == '0);
               cnt_in    = '0;
               state_in  = (post_eff == '0) ? rfb_pkg::S_DATA : rfb_pkg::S_POST;
            end
            rfb_pkg::S_POST: begin
               emit      = 1'b1;
               emit_byte = cfg.fill;
               emit_end  = (cnt_next == post_eff);
               cnt_in    = cnt_next;
               if (cnt_next == post_eff) begin
                  state_in = rfb_pkg::S_DATA;
               end
            end
            default: begin
               state_in = rfb_pkg::S_DATA;
            end
         endcase
      end
   end

   // Load or drain the output register
   always_comb begin
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_line_byte_in = rsp_line_byte_ff;
      rsp_frame_end_in = rsp_frame_end_ff;
      if (emit) begin
         rsp_valid_in     = 1'b1;
         rsp_line_byte_in = emit_byte;
         rsp_frame_end_in = emit_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rfb_pkg::S_DATA;
         cnt_ff       <= '0;
         hdr_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         hdr_done_ff  <= hdr_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      crc_hold_ff      <= crc_hold_in;
      rsp_line_byte_ff <= rsp_line_byte_in;
      rsp_frame_end_ff <= rsp_frame_end_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_line_byte = rsp_line_byte_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

endmodule

// File: design/radio_frame_builder_crc16.sv
// Top level of the radio frame builder: registers, front end, queue, back end.
//
//  channel  direction  handshake            payload
//  req_     in         req_valid/req_ready  req_payload_byte
//  rsp_     out        rsp_valid/rsp_ready  rsp_line_byte, rsp_frame_end
//  csr_     in         csr_wen              csr_index, csr_wdata
//
// Mid-frame the sequencer takes a payload byte from the queue whenever the output register can load; a
// first-of-frame byte follows preamble fill, sync and length, a last-of-frame byte precedes CRC and postamble.
// An accepted byte is registered in the 4-entry queue and then in the output register before the line.
// Reset is synchronous and returns to the start of a frame with default registers.
// Either side may stall independently; the queue absorbs bytes while the line waits.
module radio_frame_builder_crc16 (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_payload_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_line_byte,
   output logic                             rsp_frame_end,
   input  logic                             csr_wen,
   input  logic [rfb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rfb_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   rfb_pkg::rfb_cfg_type   cfg_ff, cfg_in;
   rfb_pkg::rfb_push_type  push;
   rfb_pkg::rfb_entry_type head;
   logic                   fifo_full;
   logic                   head_valid;
   logic                   pop;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            rfb_pkg::CSR_PREAMBLE:  cfg_in.preamble  = csr_wdata[5:0];
            rfb_pkg::CSR_POSTAMBLE: cfg_in.postamble = csr_wdata[5:0];
            rfb_pkg::CSR_SYNC:      cfg_in.sync      = csr_wdata;
            rfb_pkg::CSR_FILL:      cfg_in.fill      = csr_wdata;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.preamble  <= rfb_pkg::PREAMBLE_RST;
         cfg_ff.postamble <= rfb_pkg::POSTAMBLE_RST;
         cfg_ff.sync      <= rfb_pkg::SYNC_RST;
         cfg_ff.fill      <= rfb_pkg::FILL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rfb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload_byte (req_payload_byte),
      .fifo_full        (fifo_full),
      .push             (push)
   );

   rfb_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (fifo_full),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   rfb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .head_valid    (head_valid),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_line_byte (rsp_line_byte),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

// File: design/rfb_checker.sv
// Port-level checks for the radio frame builder and their binding.
module rfb_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [7:0]                     rsp_line_byte,
   input logic                           rsp_frame_end
);

   // Output is empty straight after reset
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // Queue is empty and ready straight after reset
   a_req_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("req_ready low after reset");

   // Stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_line_byte)
                                  && $stable(rsp_frame_end))
      else $error("stalled result changed");

   // A frame end is never followed at once by another frame end
   a_frame_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_frame_end |=> !(rsp_valid && rsp_frame_end))
      else $error("two frame ends in a row");

endmodule

bind radio_frame_builder_crc16 rfb_checker u_rfb_checker (.*);
